@@ rtl/core/rcn_pkg.sv @@
// ----------------------------------------------------------------------------
// rcn_pkg: shared widths, types and helpers for chromaticity normalisation
// Widths of the division pipeline, the word passed from cell to cell and the
// pre-scaling of a channel by twice the full-scale value.
// ----------------------------------------------------------------------------
package rcn_pkg;

  localparam int CH_W   = 8;               // bits per colour channel
  localparam int NCH    = 3;               // red, green, blue
  localparam int SUM_W  = CH_W + 2;        // holds the sum of three channels
  localparam int Q2_W   = CH_W + 1;        // quotient of 2*c*M/sum, one bit per cell
  localparam int REM_W  = SUM_W + Q2_W;    // partial remainder, below twice the divisor
  localparam int LATENCY = Q2_W + 2;       // prep stage, cells, output stage

  localparam logic [CH_W-1:0] CH_MAX = {CH_W{1'b1}};

  typedef logic [REM_W-1:0] rem_t;
  typedef logic [Q2_W-1:0]  quo_t;

  typedef struct packed {
    logic                  vld;
    logic                  zero;
    logic [SUM_W-1:0]      sum;
    logic [NCH-1:0][REM_W-1:0] rem;
    logic [NCH-1:0][Q2_W-1:0]  quo;
  } cell_word_t;

  // 2 * c * (2^CH_W - 1), by shift and subtract
  function automatic rem_t scale2(input logic [CH_W-1:0] c);
    rem_t prod;
    prod = REM_W'({c, {CH_W{1'b0}}}) - REM_W'(c);
    return prod << 1;
  endfunction

endpackage

@@ rtl/core/rcn_cell.sv @@
// ----------------------------------------------------------------------------
// rcn_cell: one restoring-division step for all three channels
// Compares each partial remainder with the sum aligned to the top quotient
// bit, subtracts where it fits, shifts left and appends the quotient bit.
// ----------------------------------------------------------------------------
module rcn_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  rcn_pkg::cell_word_t word_i,
  output rcn_pkg::cell_word_t word_o
);

  rcn_pkg::cell_word_t word_r;
  rcn_pkg::cell_word_t word_nxt;
  rcn_pkg::rem_t       dvs;

  always_comb begin
    rcn_pkg::rem_t diff;
    logic          ge;
    diff     = '0;
    ge       = 1'b0;
    dvs      = rcn_pkg::REM_W'(word_i.sum) << (rcn_pkg::Q2_W - 1);
    word_nxt = word_i;
    for (int l = 0; l < rcn_pkg::NCH; l++) begin
      ge   = word_i.rem[l] >= dvs;
      diff = ge ? (word_i.rem[l] - dvs) : word_i.rem[l];
      word_nxt.rem[l] = diff << 1;
      word_nxt.quo[l] = {word_i.quo[l][rcn_pkg::Q2_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.vld <= 1'b0;
    end else begin
      word_r.vld <= word_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    word_r.zero <= word_nxt.zero;
    word_r.sum  <= word_nxt.sum;
    word_r.rem  <= word_nxt.rem;
    word_r.quo  <= word_nxt.quo;
  end

  assign word_o = word_r;

  // remainder must stay below twice the aligned divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    word_r.vld && !word_r.zero |->
      (word_r.rem[0] < (rcn_pkg::REM_W'(word_r.sum) << rcn_pkg::Q2_W)) &&
      (word_r.rem[1] < (rcn_pkg::REM_W'(word_r.sum) << rcn_pkg::Q2_W)) &&
      (word_r.rem[2] < (rcn_pkg::REM_W'(word_r.sum) << rcn_pkg::Q2_W)))
    else $error("rcn_cell: partial remainder out of range");

endmodule

@@ rtl/core/rcn_round.sv @@
// ----------------------------------------------------------------------------
// rcn_round: round-to-nearest-even and output register
// Takes the doubled quotient and final remainder, rounds, forces zeros for a
// zero channel sum and registers the result word with its strobe.
// ----------------------------------------------------------------------------
module rcn_round (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rcn_pkg::cell_word_t      word_i,
  output logic                     valid_o,
  output logic [rcn_pkg::CH_W-1:0] red_o,
  output logic [rcn_pkg::CH_W-1:0] green_o,
  output logic [rcn_pkg::CH_W-1:0] blue_o,
  output logic                     zero_o
);

  logic                                  valid_r;
  logic                                  zero_r;
  logic [rcn_pkg::NCH-1:0][rcn_pkg::CH_W-1:0] norm_r;
  logic [rcn_pkg::NCH-1:0][rcn_pkg::CH_W-1:0] norm_nxt;

  always_comb begin
    logic [rcn_pkg::CH_W-1:0] q;
    logic                     up;
    logic [rcn_pkg::CH_W:0]   qr;
    q  = '0;
    up = 1'b0;
    qr = '0;
    for (int l = 0; l < rcn_pkg::NCH; l++) begin
      q  = word_i.quo[l][rcn_pkg::Q2_W-1:1];
      // half bit set: round up unless an exact tie lands on an even value
      up = word_i.quo[l][0] && ((word_i.rem[l] != '0) || q[0]);
      qr = {1'b0, q} + (rcn_pkg::CH_W+1)'(up);
      if (word_i.zero) begin
        norm_nxt[l] = '0;
      end else if (qr[rcn_pkg::CH_W]) begin
        norm_nxt[l] = rcn_pkg::CH_MAX;
      end else begin
        norm_nxt[l] = qr[rcn_pkg::CH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= word_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    zero_r <= word_i.zero;
    norm_r <= norm_nxt;
  end

  assign valid_o = valid_r;
  assign zero_o  = valid_r & zero_r;
  assign red_o   = norm_r[0];
  assign green_o = norm_r[1];
  assign blue_o  = norm_r[2];

  a_zero_strobed: assert property (@(posedge clk) disable iff (!rst_n)
    zero_o |-> valid_o)
    else $error("rcn_round: zero flag without strobe");

endmodule

@@ rtl/core/rgb_chromaticity_normalize.sv @@
// ----------------------------------------------------------------------------
// rgb_chromaticity_normalize: per-pixel chromaticity normalisation
// Each channel is scaled to round(c * 255 / (r + g + b)), ties to even, by a
// row of restoring-division cells; an all-zero pixel gives zeros and a flag.
// ----------------------------------------------------------------------------
// One pixel is taken on every clock in which start is high; busy is low at
// all times except during reset. Each pixel's word appears on the out_ ports
// for one cycle, marked by out_valid: the taking edge loads the channel sum
// and scaled numerators into the prep register, nine division cells follow
// (one quotient bit each, the last being the rounding bit), then the
// rounding/output register. Throughput is one pixel per clock. The result
// cannot be held off, so it must be captured in its strobe cycle.
module rgb_chromaticity_normalize (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [rcn_pkg::CH_W-1:0] in_red_in,
  input  logic [rcn_pkg::CH_W-1:0] in_green_in,
  input  logic [rcn_pkg::CH_W-1:0] in_blue_in,
  output logic                     out_valid,
  output logic [rcn_pkg::CH_W-1:0] out_red_norm,
  output logic [rcn_pkg::CH_W-1:0] out_green_norm,
  output logic [rcn_pkg::CH_W-1:0] out_blue_norm,
  output logic                     out_zero_sum
);

  rcn_pkg::cell_word_t prep_r;
  rcn_pkg::cell_word_t prep_nxt;
  rcn_pkg::cell_word_t chain [0:rcn_pkg::Q2_W];
  logic                accept;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  always_comb begin
    prep_nxt.vld  = accept;
    prep_nxt.sum  = rcn_pkg::SUM_W'(in_red_in) + rcn_pkg::SUM_W'(in_green_in)
                  + rcn_pkg::SUM_W'(in_blue_in);
    prep_nxt.zero = (prep_nxt.sum == '0);
    prep_nxt.rem[0] = rcn_pkg::scale2(in_red_in);
    prep_nxt.rem[1] = rcn_pkg::scale2(in_green_in);
    prep_nxt.rem[2] = rcn_pkg::scale2(in_blue_in);
    prep_nxt.quo  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_r.vld <= 1'b0;
    end else begin
      prep_r.vld <= prep_nxt.vld;
    end
  end

  // hold the payload while no word is taken
  always_ff @(posedge clk) begin
    if (accept) begin
      prep_r.zero <= prep_nxt.zero;
      prep_r.sum  <= prep_nxt.sum;
      prep_r.rem  <= prep_nxt.rem;
      prep_r.quo  <= prep_nxt.quo;
    end
  end

  assign chain[0] = prep_r;

  for (genvar k = 0; k < rcn_pkg::Q2_W; k++) begin : g_cell
    rcn_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .word_i (chain[k]),
      .word_o (chain[k+1])
    );
  end

  rcn_round u_round (
    .clk     (clk),
    .rst_n   (rst_n),
    .word_i  (chain[rcn_pkg::Q2_W]),
    .valid_o (out_valid),
    .red_o   (out_red_norm),
    .green_o (out_green_norm),
    .blue_o  (out_blue_norm),
    .zero_o  (out_zero_sum)
  );

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(accept, rcn_pkg::LATENCY) == out_valid)
    else $error("rgb_chromaticity_normalize: strobe not at fixed latency");

  a_zero_outputs: assert property (@(posedge clk) disable iff (!rst_n)
    out_zero_sum |->
      (out_red_norm == '0) && (out_green_norm == '0) && (out_blue_norm == '0))
    else $error("rgb_chromaticity_normalize: zero sum with non-zero outputs");

  a_zero_follows_input: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_red_in == '0) && (in_green_in == '0) && (in_blue_in == '0)
      |-> ##(rcn_pkg::LATENCY) out_zero_sum)
    else $error("rgb_chromaticity_normalize: zero pixel not flagged");

endmodule
